>>> hdl/mtih_pkg.sv
// Package for the muon trace integral histogram.
// Holds field widths, action/op codes, register indexes and the back-end status type.
// No dependencies.
package mtih_pkg;

    localparam int TRACE_LEN_DEF   = 63;
    localparam int NUM_BINS_DEF    = 2500;
    localparam int COUNT_WIDTH_DEF = 32;

    localparam int CFG_W      = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int POS_W      = 6;
    localparam int SAMPLE_W   = 10;
    localparam int ACC_W      = 17;
    localparam int WORD_W     = 32;
    localparam int SEL_W      = 12;
    localparam int HDR_W      = 32;
    localparam int OUT_W      = 32;
    localparam int HEADER_BIT = 31;
    localparam int Q_DEPTH    = 4;

    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_SIGNAL_START    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGNAL_END      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PEDESTAL_OFFSET = 2'd2;

    localparam logic [CFG_W-1:0] SIGNAL_START_RST    = 6'd5;
    localparam logic [CFG_W-1:0] SIGNAL_END_RST      = 6'd31;
    localparam logic [CFG_W-1:0] PEDESTAL_OFFSET_RST = 6'd30;

    typedef enum logic [1:0] {
        ACT_DATA  = 2'd0,
        ACT_CLEAR = 2'd1,
        ACT_READ  = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        OP_FILL  = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        BK_SWEEP = 2'd0,
        BK_RUN   = 2'd1,
        BK_FILL  = 2'd2
    } back_state_t;

    typedef struct packed {
        logic sweeping;
        logic sweep_done;
    } back_stat_t;

endpackage

>>> hdl/mtih_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Read data holds while re is low. No dependencies.
module mtih_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/mtih_queue.sv
// Short FIFO between the front end and the histogram back end.
// Depends on mtih_pkg for the default depth.
module mtih_queue
    import mtih_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = Q_DEPTH,
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rdata   = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

>>> hdl/mtih_front.sv
// Front end: config registers, beat classification, header tally and trace integration.
// Emits fill, read and clear ops to the queue. Depends on mtih_pkg.
module mtih_front
    import mtih_pkg::*;
#(
    parameter int TRACE_LEN = TRACE_LEN_DEF,
    parameter int NUM_BINS  = NUM_BINS_DEF,
    localparam int BIN_W = $clog2(NUM_BINS + 2)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           in_action,
    input  logic [WORD_W-1:0]    in_word,
    input  logic [SEL_W-1:0]     in_sel,
    input  back_stat_t           stat,
    input  logic                 q_full,
    output logic                 q_push,
    output op_t                  q_op,
    output logic                 q_oor,
    output logic [HDR_W-1:0]     q_hdr,
    output logic [BIN_W-1:0]     q_idx
);

    localparam logic [POS_W-1:0] LAST_POS = POS_W'(TRACE_LEN - 1);
    localparam logic [31:0]      UNDER_IDX = 32'(NUM_BINS);
    localparam logic [31:0]      OVER_IDX  = 32'(NUM_BINS + 1);
    localparam logic [31:0]      NUM_SEL   = 32'(NUM_BINS + 2);

    logic [CFG_W-1:0]        sig_start_reg, sig_end_reg, ped_off_reg;
    logic [POS_W-1:0]        pos_reg, pos_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic [HDR_W-1:0]        hdr_reg, hdr_next;
    logic                    clear_wait_reg, clear_wait_next;

    logic                    accept;
    logic [SAMPLE_W-1:0]     sample;
    logic signed [ACC_W-1:0] samp_s, acc_sum;
    logic [POS_W:0]          pos_x, ped_lo, ped_hi;
    logic                    do_add, do_sub, last;
    logic signed [31:0]      sum32;
    logic [31:0]             fidx32, sel32;
    logic [HDR_W-1:0]        hdr_inc;

    assign cfg_ready = 1'b1;
    assign in_ready  = !q_full && !clear_wait_reg;
    assign accept    = in_valid && in_ready;

    assign sample = in_word[SAMPLE_W-1:0];
    assign samp_s = $signed({{(ACC_W - SAMPLE_W){1'b0}}, sample});
    assign pos_x  = {1'b0, pos_reg};
    assign ped_lo = {1'b0, sig_start_reg} + {1'b0, ped_off_reg};
    assign ped_hi = {1'b0, sig_end_reg} + {1'b0, ped_off_reg};
    assign do_add = (pos_reg >= sig_start_reg) && (pos_reg < sig_end_reg);
    assign do_sub = (pos_x >= ped_lo) && (pos_x < ped_hi);
    assign last   = (pos_reg == LAST_POS);

    assign acc_sum = acc_reg + (do_add ? samp_s : '0) - (do_sub ? samp_s : '0);
    assign sum32   = {{(32 - ACC_W){acc_sum[ACC_W-1]}}, acc_sum};

    always_comb
    begin
        priority if (sum32 < 0)
        begin
            fidx32 = UNDER_IDX;
        end
        else if (sum32 >= $signed(32'(NUM_BINS)))
        begin
            fidx32 = OVER_IDX;
        end
        else
        begin
            fidx32 = sum32;
        end
    end

    assign sel32   = {{(32 - SEL_W){1'b0}}, in_sel};
    assign hdr_inc = (hdr_reg == '1) ? hdr_reg : hdr_reg + 1'b1;

    always_comb
    begin
        pos_next        = pos_reg;
        acc_next        = acc_reg;
        hdr_next        = hdr_reg;
        clear_wait_next = clear_wait_reg;
        q_push          = 1'b0;
        q_op            = OP_FILL;
        q_oor           = 1'b0;
        q_hdr           = hdr_reg;
        q_idx           = fidx32[BIN_W-1:0];
        if (stat.sweep_done)
        begin
            clear_wait_next = 1'b0;
        end
        if (accept)
        begin
            unique case (action_t'(in_action))
                ACT_DATA:
                begin
                    if (in_word[HEADER_BIT])
                    begin
                        hdr_next = hdr_inc;
                    end
                    else if (last)
                    begin
                        pos_next = '0;
                        acc_next = '0;
                        q_push   = 1'b1;
                    end
                    else
                    begin
                        pos_next = pos_reg + 1'b1;
                        acc_next = acc_sum;
                    end
                end
                ACT_CLEAR:
                begin
                    pos_next        = '0;
                    acc_next        = '0;
                    hdr_next        = '0;
                    clear_wait_next = 1'b1;
                    q_push          = 1'b1;
                    q_op            = OP_CLEAR;
                end
                ACT_READ:
                begin
                    q_push = 1'b1;
                    q_op   = OP_READ;
                    q_oor  = (sel32 >= NUM_SEL);
                    q_idx  = sel32[BIN_W-1:0];
                end
                ACT_NONE:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sig_start_reg  <= SIGNAL_START_RST;
            sig_end_reg    <= SIGNAL_END_RST;
            ped_off_reg    <= PEDESTAL_OFFSET_RST;
            pos_reg        <= '0;
            acc_reg        <= '0;
            hdr_reg        <= '0;
            clear_wait_reg <= 1'b1;
        end
        else
        begin
            pos_reg        <= pos_next;
            acc_reg        <= acc_next;
            hdr_reg        <= hdr_next;
            clear_wait_reg <= clear_wait_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_SIGNAL_START:    sig_start_reg <= cfg_data;
                    CFG_SIGNAL_END:      sig_end_reg   <= cfg_data;
                    CFG_PEDESTAL_OFFSET: ped_off_reg   <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

endmodule

>>> hdl/mtih_back.sv
// Back end: histogram memory, clearing sweep, saturating fill and bin read-out.
// Depends on mtih_pkg and mtih_ram.
module mtih_back
    import mtih_pkg::*;
#(
    parameter int NUM_BINS    = NUM_BINS_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
    localparam int BIN_W = $clog2(NUM_BINS + 2)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_empty,
    output logic             q_pop,
    input  op_t              q_op,
    input  logic             q_oor,
    input  logic [HDR_W-1:0] q_hdr,
    input  logic [BIN_W-1:0] q_idx,
    output back_stat_t       stat,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [OUT_W-1:0] out_bin_count,
    output logic [OUT_W-1:0] out_header_count
);

    localparam logic [BIN_W-1:0] LAST_ADDR = BIN_W'(NUM_BINS + 1);

    back_state_t            state_reg, state_next;
    logic [BIN_W-1:0]       addr_reg, addr_next;
    logic                   rd_pend_reg, rd_pend_next;
    logic [HDR_W-1:0]       pend_hdr_reg, pend_hdr_next;
    logic                   pend_oor_reg, pend_oor_next;
    logic                   out_valid_reg;
    logic [OUT_W-1:0]       out_cnt_reg, out_hdr_reg;

    logic                   ram_we, ram_re;
    logic [BIN_W-1:0]       ram_waddr;
    logic [COUNT_WIDTH-1:0] ram_wdata, ram_rdata;
    logic [63:0]            rdata64;
    logic                   out_load, rd_free;

    mtih_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (NUM_BINS + 2)
    ) u_hist_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (q_idx),
        .rdata (ram_rdata)
    );

    assign out_load = rd_pend_reg && (!out_valid_reg || out_ready);
    assign rd_free  = !rd_pend_reg || out_load;
    assign rdata64  = 64'(ram_rdata);

    always_comb
    begin
        state_next      = state_reg;
        addr_next       = addr_reg;
        rd_pend_next    = rd_pend_reg && !out_load;
        pend_hdr_next   = pend_hdr_reg;
        pend_oor_next   = pend_oor_reg;
        q_pop           = 1'b0;
        ram_re          = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = addr_reg;
        ram_wdata       = '0;
        stat.sweeping   = (state_reg == BK_SWEEP);
        stat.sweep_done = 1'b0;
        unique case (state_reg)
            BK_SWEEP:
            begin
                ram_we = 1'b1;
                if (addr_reg == LAST_ADDR)
                begin
                    addr_next       = '0;
                    state_next      = BK_RUN;
                    stat.sweep_done = 1'b1;
                end
                else
                begin
                    addr_next = addr_reg + 1'b1;
                end
            end
            BK_RUN:
            begin
                if (!q_empty)
                begin
                    case (q_op)
                        OP_FILL:
                        begin
                            if (rd_free)
                            begin
                                ram_re     = 1'b1;
                                q_pop      = 1'b1;
                                addr_next  = q_idx;
                                state_next = BK_FILL;
                            end
                        end
                        OP_READ:
                        begin
                            if (rd_free)
                            begin
                                ram_re        = 1'b1;
                                q_pop         = 1'b1;
                                rd_pend_next  = 1'b1;
                                pend_hdr_next = q_hdr;
                                pend_oor_next = q_oor;
                            end
                        end
                        OP_CLEAR:
                        begin
                            q_pop      = 1'b1;
                            addr_next  = '0;
                            state_next = BK_SWEEP;
                        end
                        default:
                        begin
                            q_pop = 1'b1;
                        end
                    endcase
                end
            end
            BK_FILL:
            begin
                // read data of the bin arrived; write back the saturated increment
                ram_we     = 1'b1;
                ram_wdata  = (ram_rdata == '1) ? ram_rdata : ram_rdata + 1'b1;
                state_next = BK_RUN;
            end
            default:
            begin
                state_next = BK_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_SWEEP;
            addr_reg      <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            addr_reg    <= addr_next;
            rd_pend_reg <= rd_pend_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_hdr_reg <= pend_hdr_next;
        pend_oor_reg <= pend_oor_next;
        if (out_load)
        begin
            out_cnt_reg <= pend_oor_reg ? '0 : rdata64[OUT_W-1:0];
            out_hdr_reg <= pend_hdr_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign out_bin_count    = out_cnt_reg;
    assign out_header_count = out_hdr_reg;

endmodule

>>> hdl/muon_trace_integral_histogram.sv
// Muon trace integral histogram, top level.
// Depends on mtih_pkg, mtih_front, mtih_queue, mtih_back (mtih_ram).
//
// Usage:
//   s_axis carries one beat per detector word or command; tuser is the action
//   (data, clear, read bin). Data beats with bit 31 set bump the header count;
//   others feed 10-bit samples into traces of TRACE_LEN samples, each full trace
//   adding one count to its integral's bin.
//   m_axis returns one beat per read: the bin count and the header count.
//   cfg writes the window registers; cfg_ready is always high.
// Throughput: one s_axis beat per cycle while s_axis_tready is high. A fill passes the
//   back end through BK_RUN and BK_FILL, a read through BK_RUN only, set by the single
//   read/write port pair of the histogram RAM; the op queue absorbs that since fills
//   come at most once per trace. A read passes the op queue, RAM read and m_axis registers.
// Reset and clear: the histogram RAM is zeroed by a sweep over all NUM_BINS+2 bins,
//   one bin per cycle; s_axis_tready stays low until the sweep ends. A clear beat
//   starts the same sweep after ops queued ahead of it.
// Stall: a stalled m_axis holds its beat; reads back up into the queue and
//   s_axis_tready drops once the queue is full.
module muon_trace_integral_histogram
    import mtih_pkg::*;
#(
    parameter int TRACE_LEN   = TRACE_LEN_DEF,
    parameter int NUM_BINS    = NUM_BINS_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // word[31:0], bin_select[43:32], zero pad
    input  logic [1:0]             s_axis_tuser,  // action[1:0]
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // bin_count[31:0], header_count[63:32]
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]       cfg_data
);

    localparam int BIN_W = $clog2(NUM_BINS + 2);
    localparam int Q_W   = 2 + 1 + HDR_W + BIN_W;

    back_stat_t       stat;
    logic             q_push, q_full, q_pop, q_empty;
    op_t              f_op;
    logic             f_oor;
    logic [HDR_W-1:0] f_hdr;
    logic [BIN_W-1:0] f_idx;
    logic [Q_W-1:0]   q_wdata, q_rdata;
    logic [OUT_W-1:0] bin_count, header_count;

    mtih_front #(
        .TRACE_LEN (TRACE_LEN),
        .NUM_BINS  (NUM_BINS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_action (s_axis_tuser),
        .in_word   (s_axis_tdata[WORD_W-1:0]),
        .in_sel    (s_axis_tdata[WORD_W +: SEL_W]),
        .stat      (stat),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_op      (f_op),
        .q_oor     (f_oor),
        .q_hdr     (f_hdr),
        .q_idx     (f_idx)
    );

    assign q_wdata = {f_op, f_oor, f_hdr, f_idx};

    mtih_queue #(
        .WIDTH (Q_W),
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    mtih_back #(
        .NUM_BINS    (NUM_BINS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_empty          (q_empty),
        .q_pop            (q_pop),
        .q_op             (op_t'(q_rdata[Q_W-1 -: 2])),
        .q_oor            (q_rdata[HDR_W + BIN_W]),
        .q_hdr            (q_rdata[BIN_W +: HDR_W]),
        .q_idx            (q_rdata[BIN_W-1:0]),
        .stat             (stat),
        .out_valid        (m_axis_tvalid),
        .out_ready        (m_axis_tready),
        .out_bin_count    (bin_count),
        .out_header_count (header_count)
    );

    assign m_axis_tdata = {header_count, bin_count};

    // no op may be offered while the queue is full
    assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_full)
        else $error("op pushed into a full queue");

    // input is closed while the histogram is being swept
    assert property (@(posedge clk) disable iff (!rst_n) stat.sweeping |-> !s_axis_tready)
        else $error("input ready during clearing sweep");

    // an accepted clear closes the input on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser == ACT_CLEAR)) |=> !s_axis_tready)
        else $error("input still ready after clear");

    // the sweep ends only while sweeping
    assert property (@(posedge clk) disable iff (!rst_n) stat.sweep_done |-> stat.sweeping)
        else $error("sweep done outside a sweep");

endmodule

>>> tb/sv/testbench.sv
// Testbench for muon_trace_integral_histogram: drives detector words, clears and bin reads,
// tracks trace integration and histogram contents itself and checks every bin read beat.
// Depends on mtih_pkg and the muon_trace_integral_histogram RTL.
module testbench;
    import mtih_pkg::*;

    localparam int NBINS          = NUM_BINS_DEF;
    localparam int UNDER_BIN      = NUM_BINS_DEF;
    localparam int OVER_BIN       = NUM_BINS_DEF + 1;
    localparam int SAMPLE_MAX     = (1 << SAMPLE_W) - 1;
    localparam int SETTLE_CYCLES  = 20;
    localparam int HOLD_CYCLES    = 250;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [HDR_W-1:0] header_count;
        logic [OUT_W-1:0] bin_count;
    } bin_read_t;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic [1:0]             s_axis_tuser  = ACT_NONE;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   cfg_valid     = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index     = '0;
    logic [CFG_W-1:0]       cfg_data      = '0;

    // histogram shadow
    int               sig_start;
    int               sig_end;
    int               ped_off;
    int               trace_pos;
    int               integral;
    logic [OUT_W-1:0] bin_tally [0:NUM_BINS_DEF+1];
    logic [HDR_W-1:0] hdr_tally;
    int               filled_bins [$];
    bin_read_t        pending_bin_reads [$];

    int src_idle_pct = 0;
    int sink_idle_pct = 0;
    bit hold_req = 1'b0;
    int hold_left = 0;
    int stuck_cycles = 0;
    int mismatches = 0;
    int beats_sent = 0;
    int reads_checked = 0;
    int traces_binned = 0;
    int clears_sent = 0;
    int windows_set = 0;

    muon_trace_integral_histogram i_dut (
        .clk,
        .rst_n,
        .s_axis_tvalid,
        .s_axis_tready,
        .s_axis_tdata,
        .s_axis_tuser,
        .m_axis_tvalid,
        .m_axis_tready,
        .m_axis_tdata,
        .cfg_valid,
        .cfg_ready,
        .cfg_index,
        .cfg_data
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void clear_histogram();
        foreach (bin_tally[i])
        begin
            bin_tally[i] = '0;
        end
        hdr_tally = '0;
        trace_pos = 0;
        integral = 0;
    endfunction

    function automatic void bin_integral(int value);
        int idx;
        if (value < 0)
            idx = UNDER_BIN;
        else if (value >= NBINS)
            idx = OVER_BIN;
        else
            idx = value;
        if (bin_tally[idx] != '1)
            bin_tally[idx]++;
        filled_bins = {filled_bins, idx};
        traces_binned++;
    endfunction

    function automatic void integrate_sample(int s);
        int p;
        p = trace_pos;
        if (p >= sig_start && p < sig_end)
            integral += s;
        if (p >= sig_start + ped_off && p < sig_end + ped_off)
            integral -= s;
        if (p + 1 >= TRACE_LEN_DEF)
        begin
            bin_integral(integral);
            integral = 0;
            trace_pos = 0;
        end
        else
        begin
            trace_pos = p + 1;
        end
    endfunction

    function automatic void apply_beat(action_t act, logic [WORD_W-1:0] w,
                                       logic [SEL_W-1:0] sel);
        bin_read_t rd;
        case (act)
            ACT_DATA:
            begin
                if (w[HEADER_BIT])
                begin
                    if (hdr_tally != '1)
                        hdr_tally++;
                end
                else
                begin
                    integrate_sample(int'(w[SAMPLE_W-1:0]));
                end
            end
            ACT_CLEAR:
            begin
                clear_histogram();
                clears_sent++;
            end
            ACT_READ:
            begin
                rd.bin_count = (int'(sel) <= OVER_BIN) ? bin_tally[sel] : '0;
                rd.header_count = hdr_tally;
                pending_bin_reads = {pending_bin_reads, rd};
            end
            default: ;
        endcase
    endfunction

    function automatic logic [SEL_W-1:0] pick_bin();
        int r;
        r = $urandom_range(99);
        if (r < 40 && filled_bins.size() > 0)
            return SEL_W'(filled_bins[$urandom_range(filled_bins.size() - 1)]);
        if (r < 55)
            return SEL_W'(UNDER_BIN);
        if (r < 70)
            return SEL_W'(OVER_BIN);
        if (r < 80)
            return SEL_W'($urandom_range(OVER_BIN + 1, (1 << SEL_W) - 1));
        return SEL_W'($urandom());
    endfunction

    function automatic void report_mismatch(string what, logic [31:0] exp_v,
                                            logic [31:0] got_v);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s expected %0d got %0d", $time, what, exp_v, got_v);
    endfunction

    // one beat on s_axis; tvalid stays high afterwards unless the next call idles
    task automatic send_beat(action_t act, logic [WORD_W-1:0] w, logic [SEL_W-1:0] sel);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W - WORD_W - SEL_W){1'b0}}, sel, w};
        s_axis_tuser  <= act;
        do
            @(posedge clk);
        while (!s_axis_tready);
        beats_sent++;
        apply_beat(act, w, sel);
    endtask

    task automatic drain_block();
        s_axis_tvalid <= 1'b0;
        while (pending_bin_reads.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_window(int start, int stop, int offset);
        logic [CFG_W-1:0]     vals [3];
        logic [CFG_IDX_W-1:0] regs [3];
        vals = '{start[CFG_W-1:0], stop[CFG_W-1:0], offset[CFG_W-1:0]};
        regs = '{CFG_SIGNAL_START, CFG_SIGNAL_END, CFG_PEDESTAL_OFFSET};
        drain_block();
        for (int i = 0; i < 3; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[i];
            cfg_data  <= vals[i];
            do
                @(posedge clk);
            while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        sig_start = start;
        sig_end = stop;
        ped_off = offset;
        windows_set++;
    endtask

    // runs until one more trace lands in the histogram; pulse rides on the signal window
    task automatic send_trace(int base, int pulse, int noise, int hdr_pct, int read_pct);
        int               r;
        int               s;
        int               target;
        logic [WORD_W-1:0] w;
        target = traces_binned + 1;
        while (traces_binned < target)
        begin
            r = $urandom_range(99);
            w = $urandom();
            if (r < hdr_pct)
            begin
                w[HEADER_BIT] = 1'b1;
                send_beat(ACT_DATA, w, SEL_W'($urandom()));
            end
            else if (r < hdr_pct + read_pct)
            begin
                send_beat(ACT_READ, w, pick_bin());
            end
            else if (read_pct > 0 && r < hdr_pct + read_pct + 2)
            begin
                send_beat(ACT_NONE, w, SEL_W'($urandom()));
            end
            else
            begin
                s = base + int'($urandom_range(0, noise));
                if (trace_pos >= sig_start && trace_pos < sig_end)
                    s += pulse;
                if (s < 0)
                    s = 0;
                if (s > SAMPLE_MAX)
                    s = SAMPLE_MAX;
                w[HEADER_BIT] = 1'b0;
                w[SAMPLE_W-1:0] = s[SAMPLE_W-1:0];
                send_beat(ACT_DATA, w, SEL_W'($urandom()));
            end
        end
    endtask

    task automatic test_empty_reads();
        send_beat(ACT_READ, 32'hFFFF_FFFF, 12'd0);
        send_beat(ACT_READ, 32'h0000_0000, SEL_W'(NBINS - 1));
        send_beat(ACT_READ, $urandom(), SEL_W'(UNDER_BIN));
        send_beat(ACT_READ, $urandom(), SEL_W'(OVER_BIN));
        send_beat(ACT_READ, $urandom(), SEL_W'(OVER_BIN + 1));
        send_beat(ACT_READ, $urandom(), 12'hFFF);
        send_beat(ACT_DATA, 32'h8000_0000, 12'hFFF);
        send_beat(ACT_DATA, 32'hFFFF_FFFF, 12'h000);
        send_beat(ACT_NONE, 32'h7FFF_FFFF, 12'hFFF);
        send_beat(ACT_READ, $urandom(), SEL_W'(OVER_BIN));
    endtask

    task automatic test_full_scale_trace();
        send_trace(SAMPLE_MAX, 0, 0, 0, 0);
        send_trace(0, 0, 0, 10, 0);
        send_beat(ACT_READ, $urandom(), 12'd0);
    endtask

    task automatic test_clear_partial_trace();
        for (int i = 0; i < 20; i++)
        begin
            send_beat(ACT_DATA, 32'h0000_03FF, SEL_W'($urandom()));
        end
        send_beat(ACT_DATA, 32'hC000_0000, SEL_W'($urandom()));
        send_beat(ACT_CLEAR, $urandom(), SEL_W'($urandom()));
        send_beat(ACT_READ, $urandom(), 12'd0);
        send_trace(100, 50, 0, 0, 0);
        send_beat(ACT_READ, $urandom(), 12'd1300);
        send_beat(ACT_READ, $urandom(), 12'd0);
    endtask

    task automatic test_window_cases();
        // empty window
        set_window(40, 10, 5);
        send_trace(300, 0, 700, 0, 0);
        send_beat(ACT_READ, $urandom(), 12'd0);
        // pedestal runs past the end of the trace
        set_window(40, 63, 30);
        send_trace(0, 100, 0, 0, 0);
        send_beat(ACT_READ, $urandom(), 12'd2300);
        send_trace(SAMPLE_MAX, 0, 0, 0, 0);
        send_beat(ACT_READ, $urandom(), SEL_W'(OVER_BIN));
        // negative integral
        set_window(0, 5, 5);
        send_trace(SAMPLE_MAX, -SAMPLE_MAX, 0, 0, 0);
        send_beat(ACT_READ, $urandom(), SEL_W'(UNDER_BIN));
        // value right at the top of the range
        set_window(58, 63, 10);
        send_trace(500, 0, 0, 0, 0);
        send_trace(0, 499, 0, 0, 0);
        send_beat(ACT_READ, $urandom(), SEL_W'(OVER_BIN));
        send_beat(ACT_READ, $urandom(), 12'd2495);
    endtask

    task automatic test_random_traffic();
        int               seg;
        int               stop_at;
        int               base;
        int               pulse;
        int               noise;
        action_t          act;
        logic [SEL_W-1:0] sel;
        for (int mode = 0; mode < 3; mode++)
        begin
            case (mode)
                0:
                begin
                    src_idle_pct = 13;
                    sink_idle_pct = 53;
                end
                1:
                begin
                    src_idle_pct = 53;
                    sink_idle_pct = 13;
                end
                default:
                begin
                    src_idle_pct = 0;
                    sink_idle_pct = 0;
                end
            endcase
            for (int half = 0; half < 2; half++)
            begin
                seg = mode * 2 + half;
                case (seg)
                    0: set_window(0, 63, 0);
                    1: set_window(62, 63, 62);
                    2: set_window(0, 1, 62);
                    5: set_window(SIGNAL_START_RST, SIGNAL_END_RST, PEDESTAL_OFFSET_RST);
                    default: set_window($urandom_range(0, 62), $urandom_range(1, 63),
                                        $urandom_range(0, 62));
                endcase
                if ($urandom_range(3) == 0)
                    send_beat(ACT_CLEAR, $urandom(), SEL_W'($urandom()));
                stop_at = beats_sent + 40;
                while (beats_sent < stop_at)
                begin
                    repeat ($urandom_range(2))
                    begin
                        act = action_t'($urandom_range(3));
                        if (act == ACT_CLEAR && $urandom_range(3) != 0)
                            act = ACT_READ;
                        sel = (act == ACT_READ) ? pick_bin() : SEL_W'($urandom());
                        send_beat(act, $urandom(), sel);
                    end
                    if ($urandom_range(9) == 0)
                    begin
                        base = 0;
                        pulse = 0;
                        noise = SAMPLE_MAX;
                    end
                    else
                    begin
                        base = $urandom_range(0, 900);
                        pulse = int'($urandom_range(0, 180)) - 60;
                        noise = $urandom_range(0, 30);
                    end
                    send_trace(base, pulse, noise, 4, 15);
                end
            end
        end
    endtask

    task automatic test_backpressure();
        hold_req = 1'b1;
        for (int i = 0; i < 40; i++)
        begin
            if (i % 5 == 4)
                send_beat(ACT_DATA, $urandom_range(0, SAMPLE_MAX), SEL_W'($urandom()));
            else
                send_beat(ACT_READ, $urandom(), pick_bin());
        end
    endtask

    // result sink with its own hold-off counter
    always @(posedge clk)
    begin
        if (hold_req)
        begin
            hold_left = HOLD_CYCLES;
            hold_req = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        bin_read_t expected;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_bin_reads.size() == 0)
            begin
                report_mismatch("unrequested beat, bin_count", '0, m_axis_tdata[OUT_W-1:0]);
            end
            else
            begin
                expected = pending_bin_reads.pop_front();
                reads_checked++;
                if (m_axis_tdata[OUT_W-1:0] !== expected.bin_count)
                    report_mismatch("bin_count", expected.bin_count,
                                    m_axis_tdata[OUT_W-1:0]);
                if (m_axis_tdata[OUT_W+HDR_W-1:OUT_W] !== expected.header_count)
                    report_mismatch("header_count", expected.header_count,
                                    m_axis_tdata[OUT_W+HDR_W-1:OUT_W]);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
        begin
            stuck_cycles <= 0;
        end
        else if (stuck_cycles >= WATCHDOG_LIMIT)
        begin
            $display("no beat moved for %0d cycles", WATCHDOG_LIMIT);
            $display("muon_trace_integral_histogram: mismatch");
            $finish;
        end
        else
        begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial
    begin
        sig_start = SIGNAL_START_RST;
        sig_end = SIGNAL_END_RST;
        ped_off = PEDESTAL_OFFSET_RST;
        clear_histogram();
        src_idle_pct = 13;
        sink_idle_pct = 53;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_reads();
        test_full_scale_trace();
        test_clear_partial_trace();
        test_window_cases();
        test_random_traffic();
        test_backpressure();

        drain_block();
        if (pending_bin_reads.size() != 0)
            report_mismatch("reads never answered", 0, pending_bin_reads.size());
        $display("covered %0d beats, %0d window settings, %0d clears, %0d traces binned",
                 beats_sent, windows_set, clears_sent, traces_binned);
        $display("%0d bin reads compared, with headers, ignored actions and a held sink",
                 reads_checked);
        if (mismatches == 0)
            $display("muon_trace_integral_histogram: match");
        else
            $display("muon_trace_integral_histogram: mismatch");
        $finish;
    end

endmodule

>>> muon_trace_integral_histogram.f
hdl/mtih_pkg.sv
hdl/mtih_ram.sv
hdl/mtih_queue.sv
hdl/mtih_front.sv
hdl/mtih_back.sv
hdl/muon_trace_integral_histogram.sv
tb/sv/testbench.sv
